// ===== hdl/gaussian_heat_source_point_defines.svh =====
// assertion helpers shared by the heat source point block
`ifndef GAUSSIAN_HEAT_SOURCE_POINT_DEFINES_SVH
`define GAUSSIAN_HEAT_SOURCE_POINT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define GHS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define GHS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ghs_pkg.sv =====
package ghs_pkg;

  localparam int POS_W      = 11;
  localparam int CENTER_W   = 10;
  localparam int COEF_W     = 24;
  localparam int SCALE_W    = 32;
  localparam int HEAT_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // grid points per axis; positions count from one
  localparam int AXIS_POINTS = 1024;

  // exp argument layout, unsigned Q.24
  localparam int ARG_FRAC_W = 24;
  localparam int ARG_LIMIT  = 16 << ARG_FRAC_W;
  localparam int RED_W      = 20;
  localparam int EXP_STEPS  = 9;
  localparam int R32_W      = RED_W + 8;
  localparam int R2_W       = 2 * R32_W - 32;
  localparam int R3_W       = R2_W + R32_W - 32;
  localparam int P_W        = 33;

  // floor(x/6) = (x * DIV6_MUL) >> DIV6_SHIFT for x < 2^21
  localparam logic [19:0] DIV6_MUL   = 20'd699051;
  localparam int          DIV6_SHIFT = 22;
  localparam int          Q_W        = R3_W - 2;

  // exp(-w) in Q0.32 for w = 16, 8, 4, 2, 1, 1/2, 1/4, 1/8, 1/16
  localparam logic [31:0] EXP_TAB [EXP_STEPS] = '{
    32'd483,        32'd1440801,    32'd78665070,
    32'd581260614,  32'd1580030169, 32'd2605029347,
    32'd3344923893, 32'd3790295336, 32'd4034748385
  };

  localparam int AXIS_LAT  = 8 + EXP_STEPS + 1;
  localparam int SCALE_LAT = 2;
  localparam int PIPE_LAT  = AXIS_LAT + SCALE_LAT;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_ROW     = 3'd0,
    CFG_CENTER_COL     = 3'd1,
    CFG_ROW_WIDTH_COEF = 3'd2,
    CFG_COL_WIDTH_COEF = 3'd3,
    CFG_PEAK_SCALE     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic              valid;
    logic [HEAT_W-1:0] heat;
  } heat_xfer_t;

endpackage

// ===== hdl/gaussian_heat_source_point.sv =====
// Gaussian heat source: for each grid point (row, col), counted from one, returns
// peak_scale * exp(-(row-center_row)^2*row_width_coef) * exp(-(col-center_col)^2*col_width_coef)
// with both exp terms in unsigned Q0.GAUSS_FRAC_BITS and the product shifted down by
// 2*GAUSS_FRAC_BITS; a point off the grid gives 0. One point is taken every cycle while in_stall is
// low; the latency is set by the exp evaluation, which runs nine table multiplies in a row, one
// pipeline stage each, after the argument and polynomial stages. A two-entry output buffer lets the
// pipeline keep moving after the output stalls until a result fills its spare entry, so the input
// stalls only when that spare entry is full. The user must write registers through the cfg port
// only while no point is in flight; the block itself does not enforce it.
`include "gaussian_heat_source_point_defines.svh"

module gaussian_heat_source_point import ghs_pkg::*; #(
  parameter int GAUSS_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [POS_W-1:0]      in_row_pos,
  input  logic [POS_W-1:0]      in_col_pos,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [HEAT_W-1:0]     out_heat_value,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [31:0] AXIS_MAX = 32'(AXIS_POINTS);

  logic [CENTER_W-1:0] center_row_r;
  logic [CENTER_W-1:0] center_col_r;
  logic [COEF_W-1:0]   row_width_coef_r;
  logic [COEF_W-1:0]   col_width_coef_r;
  logic [SCALE_W-1:0]  peak_scale_r;

  logic ready;
  logic valid_r [PIPE_LAT];
  logic off_r   [PIPE_LAT];
  logic off_nxt;

  logic [GAUSS_FRAC_BITS-1:0] gx;
  logic [GAUSS_FRAC_BITS-1:0] gy;
  logic [HEAT_W-1:0]          heat;
  heat_xfer_t                 push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_row_r     <= '0;
      center_col_r     <= '0;
      row_width_coef_r <= COEF_W'(24'h800000);
      col_width_coef_r <= COEF_W'(24'h800000);
      peak_scale_r     <= SCALE_W'(32'd65536);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CENTER_ROW:     center_row_r     <= cfg_data[CENTER_W-1:0];
        CFG_CENTER_COL:     center_col_r     <= cfg_data[CENTER_W-1:0];
        CFG_ROW_WIDTH_COEF: row_width_coef_r <= cfg_data[COEF_W-1:0];
        CFG_COL_WIDTH_COEF: col_width_coef_r <= cfg_data[COEF_W-1:0];
        CFG_PEAK_SCALE:     peak_scale_r     <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign off_nxt = (in_row_pos == '0) || (in_col_pos == '0) ||
                   (32'(in_row_pos) > AXIS_MAX) || (32'(in_col_pos) > AXIS_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE_LAT; k++) begin
        valid_r[k] <= 1'b0;
      end
    end else if (ready) begin
      valid_r[0] <= in_valid;
      for (int k = 1; k < PIPE_LAT; k++) begin
        valid_r[k] <= valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      off_r[0] <= off_nxt;
      for (int k = 1; k < PIPE_LAT; k++) begin
        off_r[k] <= off_r[k-1];
      end
    end
  end

  ghs_axis #(.GAUSS_FRAC_BITS(GAUSS_FRAC_BITS)) u_axis_row (
    .clk    (clk),
    .en     (ready),
    .pos    (in_row_pos),
    .center (center_row_r),
    .coef   (row_width_coef_r),
    .term   (gx)
  );

  ghs_axis #(.GAUSS_FRAC_BITS(GAUSS_FRAC_BITS)) u_axis_col (
    .clk    (clk),
    .en     (ready),
    .pos    (in_col_pos),
    .center (center_col_r),
    .coef   (col_width_coef_r),
    .term   (gy)
  );

  ghs_scale #(.GAUSS_FRAC_BITS(GAUSS_FRAC_BITS)) u_scale (
    .clk        (clk),
    .en         (ready),
    .peak_scale (peak_scale_r),
    .gx         (gx),
    .gy         (gy),
    .heat       (heat)
  );

  // last stage moves into the output buffer whenever the pipeline advances
  assign push.valid = ready && valid_r[PIPE_LAT-1];
  assign push.heat  = off_r[PIPE_LAT-1] ? '0 : heat;

  ghs_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .ready     (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_heat  (out_heat_value)
  );

  assign in_stall = !ready;

  `GHS_ASSERT_IMP(a_stall_needs_result, clk, rst_n, in_stall, out_valid, "input stalled while no result is held")
  `GHS_ASSERT_NXT(a_transfer_enters, clk, rst_n, in_valid && !in_stall, valid_r[0], "accepted point missing from first stage")
  `GHS_ASSERT_IMP(a_skid_fill_cause, clk, rst_n, $fell(ready), $past(push.valid), "spare entry filled without a result")

endmodule

// ===== hdl/ghs_axis.sv =====
module ghs_axis import ghs_pkg::*; #(
  parameter int GAUSS_FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [POS_W-1:0]           pos,
  input  logic [CENTER_W-1:0]        center,
  input  logic [COEF_W-1:0]          coef,
  output logic [GAUSS_FRAC_BITS-1:0] term
);

  localparam int F    = GAUSS_FRAC_BITS;
  localparam int DD_W = 2 * POS_W;
  localparam int A_W  = DD_W + COEF_W;

  localparam logic [P_W-1:0]   ONE_Q32   = P_W'(64'd1 << 32);
  localparam logic [P_W-1:0]   TERM_RND  = P_W'(64'd1 << (31 - F));
  localparam logic [2*P_W-1:0] STEP_RND  = (2*P_W)'(64'd1 << 31);

  logic [POS_W-1:0]     d_r,   d_nxt;
  logic [DD_W-1:0]      dd_r,  dd_nxt;
  logic [A_W-1:0]       a_r,   a_nxt;

  logic                 big4_r, big4_nxt;
  logic [EXP_STEPS-1:0] w4_r,   w4_nxt;
  logic [R32_W-1:0]     r32_4_r, r32_4_nxt;

  logic [2*R32_W-1:0]   sq;
  logic                 big5_r;
  logic [EXP_STEPS-1:0] w5_r;
  logic [R32_W-1:0]     r32_5_r;
  logic [R2_W-1:0]      r2_r, r2_nxt;

  logic [R2_W+R32_W-1:0] cube;
  logic                 big6_r;
  logic [EXP_STEPS-1:0] w6_r;
  logic [R3_W-1:0]      r3_r, r3_nxt;
  logic [P_W-1:0]       pp6_r, pp6_nxt;

  logic [R3_W+19:0]     quo;
  logic                 big7_r;
  logic [EXP_STEPS-1:0] w7_r;
  logic [Q_W-1:0]       q_r, q_nxt;
  logic [P_W-1:0]       pp7_r;

  logic [P_W-1:0]       p_r    [EXP_STEPS+1];
  logic                 bigm_r [EXP_STEPS+1];
  logic [EXP_STEPS-1:0] wm_r   [EXP_STEPS+1];
  logic [P_W-1:0]       p0_nxt;
  logic [2*P_W-1:0]     prod   [EXP_STEPS];
  logic [P_W-1:0]       step_nxt [EXP_STEPS];

  logic [P_W-1:0]       rnd;
  logic [F:0]           g;
  logic [F-1:0]         term_r, term_nxt;

  always_comb begin
    d_nxt  = (pos >= POS_W'(center)) ? pos - POS_W'(center) : POS_W'(center) - pos;
    dd_nxt = DD_W'(d_r) * DD_W'(d_r);
    a_nxt  = A_W'(dd_r) * A_W'(coef);

    big4_nxt  = a_r > A_W'(ARG_LIMIT);
    w4_nxt    = a_r[RED_W +: EXP_STEPS];
    r32_4_nxt = {a_r[RED_W-1:0], 8'b0};

    // second and third powers of the reduced argument, Q0.32
    sq     = (2*R32_W)'(r32_4_r) * (2*R32_W)'(r32_4_r);
    r2_nxt = sq[2*R32_W-1:32];

    cube    = (R2_W+R32_W)'(r2_r) * (R2_W+R32_W)'(r32_5_r);
    r3_nxt  = cube[R2_W+R32_W-1:32];
    pp6_nxt = ONE_Q32 - P_W'(r32_5_r) + P_W'(r2_r[R2_W-1:1]);

    quo   = (R3_W+20)'(r3_r) * (R3_W+20)'(DIV6_MUL);
    q_nxt = quo[DIV6_SHIFT +: Q_W];

    p0_nxt = pp7_r - P_W'(q_r);

    // one table factor per stage, weight 16 first
    for (int k = 0; k < EXP_STEPS; k++) begin
      prod[k]     = (2*P_W)'(p_r[k]) * (2*P_W)'(EXP_TAB[k]) + STEP_RND;
      step_nxt[k] = wm_r[k][EXP_STEPS-1-k] ? prod[k][32 +: P_W] : p_r[k];
    end

    rnd = p_r[EXP_STEPS] + TERM_RND;
    g   = rnd[P_W-1 -: F+1];
    if (bigm_r[EXP_STEPS]) begin
      term_nxt = '0;
    end else if (g[F]) begin
      term_nxt = '1;
    end else begin
      term_nxt = g[F-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r     <= d_nxt;
      dd_r    <= dd_nxt;
      a_r     <= a_nxt;
      big4_r  <= big4_nxt;
      w4_r    <= w4_nxt;
      r32_4_r <= r32_4_nxt;
      big5_r  <= big4_r;
      w5_r    <= w4_r;
      r32_5_r <= r32_4_r;
      r2_r    <= r2_nxt;
      big6_r  <= big5_r;
      w6_r    <= w5_r;
      r3_r    <= r3_nxt;
      pp6_r   <= pp6_nxt;
      big7_r  <= big6_r;
      w7_r    <= w6_r;
      q_r     <= q_nxt;
      pp7_r   <= pp6_r;
      p_r[0]    <= p0_nxt;
      bigm_r[0] <= big7_r;
      wm_r[0]   <= w7_r;
      for (int k = 0; k < EXP_STEPS; k++) begin
        p_r[k+1]    <= step_nxt[k];
        bigm_r[k+1] <= bigm_r[k];
        wm_r[k+1]   <= wm_r[k];
      end
      term_r <= term_nxt;
    end
  end

  assign term = term_r;

endmodule

// ===== hdl/ghs_scale.sv =====
module ghs_scale import ghs_pkg::*; #(
  parameter int GAUSS_FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [SCALE_W-1:0]         peak_scale,
  input  logic [GAUSS_FRAC_BITS-1:0] gx,
  input  logic [GAUSS_FRAC_BITS-1:0] gy,
  output logic [HEAT_W-1:0]          heat
);

  localparam int F    = GAUSS_FRAC_BITS;
  localparam int T_W  = SCALE_W + F;
  localparam int HI_W = 2 * F;
  localparam int FW   = 32 + 2 * F;

  logic [T_W-1:0]  t_r,  t_nxt;
  logic [F-1:0]    gy_r;
  logic [T_W-1:0]  lo_r, lo_nxt;
  logic [HI_W-1:0] hi_r, hi_nxt;
  logic [FW-1:0]   full;

  always_comb begin
    t_nxt  = T_W'(peak_scale) * T_W'(gx);
    // t is split at bit 32 so each product stays within a 32xGAUSS_FRAC_BITS multiplier
    lo_nxt = T_W'(t_r[31:0]) * T_W'(gy_r);
    hi_nxt = HI_W'(t_r[T_W-1:32]) * HI_W'(gy_r);
    full   = FW'(lo_r) + (FW'(hi_r) << 32);
    heat   = full[2*F +: HEAT_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r  <= t_nxt;
      gy_r <= gy;
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

endmodule

// ===== hdl/ghs_obuf.sv =====
module ghs_obuf import ghs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  heat_xfer_t        push,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HEAT_W-1:0] out_heat
);

  logic              out_valid_r, out_valid_nxt;
  logic [HEAT_W-1:0] out_heat_r,  out_heat_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic [HEAT_W-1:0] skid_heat_r,  skid_heat_nxt;
  logic              pop;

  always_comb begin
    pop            = out_valid_r && !out_stall;
    out_valid_nxt  = out_valid_r;
    out_heat_nxt   = out_heat_r;
    skid_valid_nxt = skid_valid_r;
    skid_heat_nxt  = skid_heat_r;
    if (skid_valid_r) begin
      // pipeline is held while the skid entry is occupied
      if (pop) begin
        out_heat_nxt   = skid_heat_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push.valid) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        out_heat_nxt  = push.heat;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_heat_nxt  = push.heat;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_heat_r  <= out_heat_nxt;
    skid_heat_r <= skid_heat_nxt;
  end

  assign ready     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_heat  = out_heat_r;

endmodule

// ===== tb/sv/gaussian_heat_source_point_tb.sv =====
module gaussian_heat_source_point_tb;
  import ghs_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int HOLD_CYCLES = 150;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PHASES = 6;
  localparam int POINTS_PER_PHASE = 170;
  localparam int HOLDOFF_POINTS = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = 3'd5;

  // exp(-w) in Q0.32 for w = 16, 8, 4, 2, 1, 1/2, 1/4, 1/8, 1/16
  localparam logic [63:0] EXP_NEG_Q32 [9] = '{
    64'd483,        64'd1440801,    64'd78665070,
    64'd581260614,  64'd1580030169, 64'd2605029347,
    64'd3344923893, 64'd3790295336, 64'd4034748385
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [POS_W-1:0]      in_row_pos = '0;
  logic [POS_W-1:0]      in_col_pos = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [HEAT_W-1:0]     out_heat_value;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register shadow, reset values
  logic [CENTER_W-1:0] src_center_row = '0;
  logic [CENTER_W-1:0] src_center_col = '0;
  logic [COEF_W-1:0]   src_row_coef = 24'h800000;
  logic [COEF_W-1:0]   src_col_coef = 24'h800000;
  logic [SCALE_W-1:0]  src_peak = 32'd65536;

  logic [HEAT_W-1:0] heat_expected_q [$];
  int points_sent = 0;
  int heats_checked = 0;
  int fail_count = 0;
  int settings_used = 1;
  int cycle_count = 0;
  int stall_left = 0;
  int row_span = 0;
  int col_span = 0;
  logic idle_en = 1'b1;
  logic hold_pending = 1'b0;
  logic hold_off = 1'b0;

  gaussian_heat_source_point uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_row_pos     (in_row_pos),
    .in_col_pos     (in_col_pos),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_heat_value (out_heat_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one axis term exp(-(pos-centre)^2 * coef), unsigned Q0.16
  function automatic logic [FRAC_BITS-1:0] axis_gauss(input logic [POS_W-1:0] pos,
                                                      input logic [CENTER_W-1:0] centre,
                                                      input logic [COEF_W-1:0] coef);
    logic [63:0] pz, cz, d, arg, r32, r2, r3, p, g;
    pz = 64'(pos);
    cz = 64'(centre);
    d = (pz >= cz) ? pz - cz : cz - pz;
    arg = d * d * {40'd0, coef};
    if (arg > (64'd16 << 24))
      return '0;
    r32 = (arg & 64'hFFFFF) << 8;
    r2 = (r32 * r32) >> 32;
    r3 = (r2 * r32) >> 32;
    p = (64'd1 << 32) - r32 + (r2 >> 1) - r3 / 64'd6;
    // walk the integer and coarse fractional bits of the argument
    for (int k = 0; k < 9; k++) begin
      if (arg[28-k])
        p = (p * EXP_NEG_Q32[k] + (64'd1 << 31)) >> 32;
    end
    g = (p + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    if (g > ((64'd1 << FRAC_BITS) - 1))
      return '1;
    return g[FRAC_BITS-1:0];
  endfunction

  function automatic logic [HEAT_W-1:0] heat_at_point(input logic [POS_W-1:0] row,
                                                      input logic [POS_W-1:0] col);
    logic [63:0] t;
    logic [127:0] prod;
    if (row == 0 || col == 0 || row > AXIS_POINTS || col > AXIS_POINTS)
      return '0;
    t = {32'd0, src_peak} * {48'd0, axis_gauss(row, src_center_row, src_row_coef)};
    prod = {64'd0, t} * {112'd0, axis_gauss(col, src_center_col, src_col_coef)};
    return prod[63:32];
  endfunction

  // largest offset worth aiming at: argument a bit past the cut-off
  function automatic int reach_of(input logic [COEF_W-1:0] coef);
    logic [63:0] s;
    s = 64'd1;
    while (s < 1024 && s * s * {40'd0, coef} <= (64'd17 << 24))
      s++;
    return int'(s);
  endfunction

  function automatic int burst_len();
    if ($urandom_range(0, 99) < 85)
      return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [31:0] with_junk(input logic [31:0] v, input int w);
    if (w < 32 && $urandom_range(0, 1))
      return ($urandom() << w) | v;
    return v;
  endfunction

  function automatic logic [POS_W-1:0] near_pos(input logic [CENTER_W-1:0] centre,
                                                input int span);
    int d, p;
    d = $urandom_range(0, span);
    p = $urandom_range(0, 1) ? int'(centre) + d : int'(centre) - d;
    if (p < 1 || p > AXIS_POINTS)
      p = $urandom_range(1, AXIS_POINTS);
    return POS_W'(p);
  endfunction

  task automatic shadow_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    case (idx)
      CFG_CENTER_ROW:     src_center_row = data[CENTER_W-1:0];
      CFG_CENTER_COL:     src_center_col = data[CENTER_W-1:0];
      CFG_ROW_WIDTH_COEF: src_row_coef = data[COEF_W-1:0];
      CFG_COL_WIDTH_COEF: src_col_coef = data[COEF_W-1:0];
      CFG_PEAK_SCALE:     src_peak = data;
      default: ;
    endcase
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    shadow_write(idx, data);
    @(posedge clk);
  endtask

  task automatic set_source(input logic [31:0] crow, input logic [31:0] ccol,
                            input logic [31:0] kx, input logic [31:0] ky,
                            input logic [31:0] peak);
    put_reg(CFG_CENTER_ROW, crow);
    put_reg(CFG_CENTER_COL, ccol);
    put_reg(CFG_ROW_WIDTH_COEF, kx);
    put_reg(CFG_COL_WIDTH_COEF, ky);
    put_reg(CFG_PEAK_SCALE, peak);
    // unmapped index must leave every register alone
    put_reg(CFG_FIRST_SPARE + CFG_IDX_W'($urandom_range(0, 2)), $urandom());
    cfg_we <= 1'b0;
    row_span = reach_of(src_row_coef);
    col_span = reach_of(src_col_coef);
    settings_used++;
  endtask

  task automatic send_point(input logic [POS_W-1:0] row, input logic [POS_W-1:0] col);
    int gap;
    logic taken;
    gap = (idle_en && $urandom_range(0, 1)) ? burst_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_row_pos <= row;
    in_col_pos <= col;
    // stall is settled by the falling edge, so sample it there
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    heat_expected_q.push_back(heat_at_point(row, col));
    points_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (heat_expected_q.size() != 0)
      @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_point(11'd1, 11'd1);
    send_point(11'd2, 11'd1);
    send_point(11'd1, 11'd2);
    send_point(11'd1024, 11'd1024);
    send_point(11'd0, 11'd1);
    send_point(11'd1, 11'd0);
    send_point(11'd1025, 11'd1);
    send_point(11'd1, 11'd2047);
    send_point(11'd2047, 11'd2047);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    // zero width coefficients: both terms saturate everywhere
    set_source(with_junk(32'd512, CENTER_W), with_junk(32'd512, CENTER_W),
               32'd0, 32'd0, 32'hFFFF_FFFF);
    send_point(11'd512, 11'd512);
    send_point(11'd1, 11'd1024);
    send_point(11'd1024, 11'd1);
    wait_drained();
    set_source(with_junk(32'd1023, CENTER_W), with_junk(32'd1023, CENTER_W),
               32'hFF_FFFF, 32'hFF_FFFF, 32'h8000_0000);
    send_point(11'd1023, 11'd1023);
    send_point(11'd1024, 11'd1023);
    send_point(11'd1023, 11'd1022);
    send_point(11'd1, 11'd1);
    wait_drained();
    // offset 8 at coef 2^22 lands exactly on the cut-off, offset 9 just past it
    set_source(32'd100, 32'd200, 32'd4194304, 32'd4194304, 32'hFFFF_FFFF);
    send_point(11'd108, 11'd200);
    send_point(11'd109, 11'd200);
    send_point(11'd100, 11'd192);
    send_point(11'd92, 11'd208);
    wait_drained();
    set_source(32'd0, 32'd0, 32'd1, 32'd1, 32'd0);
    send_point(11'd1, 11'd1);
    wait_drained();
  endtask

  task automatic test_random_phases();
    logic [31:0] crow, ccol, kx, ky, peak;
    logic [POS_W-1:0] row, col;
    int sel;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_en <= (ph != 2);
      crow = (ph == 0) ? 32'd0 : (ph == 1) ? 32'd1023 : $urandom_range(0, 1023);
      ccol = (ph == 0) ? 32'd1023 : (ph == 1) ? 32'd0 : $urandom_range(0, 1023);
      kx = (ph == 3) ? 32'hFF_FFFF : $urandom() >> $urandom_range(8, 31);
      ky = (ph == 4) ? 32'd0 : $urandom() >> $urandom_range(8, 31);
      peak = (ph == 5) ? 32'hFFFF_FFFF : $urandom();
      set_source(with_junk(crow, CENTER_W), with_junk(ccol, CENTER_W),
                 with_junk(kx, COEF_W), with_junk(ky, COEF_W), peak);
      repeat (POINTS_PER_PHASE) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          row = near_pos(src_center_row, row_span);
          col = near_pos(src_center_col, col_span);
        end else if (sel < 85) begin
          row = POS_W'($urandom_range(1, AXIS_POINTS));
          col = POS_W'($urandom_range(1, AXIS_POINTS));
        end else begin
          row = POS_W'($urandom_range(0, 2047));
          col = POS_W'($urandom_range(0, 2047));
        end
        send_point(row, col);
      end
      wait_drained();
    end
    idle_en <= 1'b1;
  endtask

  task automatic test_output_holdoff();
    set_source(32'd300, 32'd700, 32'd16384, 32'd65536, $urandom());
    idle_en <= 1'b0;
    hold_pending <= 1'b1;
    repeat (HOLDOFF_POINTS)
      send_point(near_pos(src_center_row, row_span), near_pos(src_center_col, col_span));
    wait_drained();
    idle_en <= 1'b1;
  endtask

  // long receiver hold-off, requested by the pressure test
  always begin
    @(posedge clk);
    if (hold_pending) begin
      hold_pending <= 1'b0;
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0)
      stall_left--;
    else if (idle_en && $urandom_range(0, 3) == 0)
      stall_left = burst_len();
    out_stall <= hold_off || (stall_left > 0);
  end

  // a transfer happens at the next rising edge if this holds at the falling edge
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (heat_expected_q.size() == 0) begin
        $error("heat_value: no result expected, got %0d", out_heat_value);
        fail_count++;
      end else begin
        if (out_heat_value !== heat_expected_q[0]) begin
          $error("heat_value mismatch: expected %0d, got %0d",
                 heat_expected_q[0], out_heat_value);
          fail_count++;
        end
        void'(heat_expected_q.pop_front());
        heats_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    row_span = reach_of(src_row_coef);
    col_span = reach_of(src_col_coef);
    test_reset_state();
    test_register_extremes();
    test_random_phases();
    test_output_holdoff();
    $display("run covered %0d grid points under %0d register settings, %0d results compared",
             points_sent, settings_used, heats_checked);
    $display("including off-grid points, saturated and cut-off terms and a long output hold-off");
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
